// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/matinv_pkg.sv =====
// ---------------------------------------------------------------------------
// matinv_pkg
// Types and constants for the 3x3 fixed-point matrix inverse unit.
// ---------------------------------------------------------------------------
package matinv_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DET_W   = 97;               // signed full-width determinant
   localparam int DMAG_W  = DET_W - 1;        // determinant magnitude
   localparam int DEN_W   = DET_W;            // twice the magnitude
   localparam int COF_W   = 64;               // cofactor magnitude
   localparam int QUO_W   = 32;               // quotient bits kept
   localparam int DIV_LAT = QUO_W + 1;        // divider depth

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   typedef struct packed {
      logic signed [31:0] m_r0c0;
      logic signed [31:0] m_r0c1;
      logic signed [31:0] m_r0c2;
      logic signed [31:0] m_r1c0;
      logic signed [31:0] m_r1c1;
      logic signed [31:0] m_r1c2;
      logic signed [31:0] m_r2c0;
      logic signed [31:0] m_r2c1;
      logic signed [31:0] m_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] inv_r0c0;
      logic signed [31:0] inv_r0c1;
      logic signed [31:0] inv_r0c2;
      logic signed [31:0] inv_r1c0;
      logic signed [31:0] inv_r1c1;
      logic signed [31:0] inv_r1c2;
      logic signed [31:0] inv_r2c0;
      logic signed [31:0] inv_r2c1;
      logic signed [31:0] inv_r2c2;
      logic signed [31:0] det_value;
      logic [1:0]         status;
   } rsp_type;

   // Word state that rides alongside the dividers
   typedef struct packed {
      logic        sing;
      logic        det_sat;
      logic [31:0] det_val;
      logic [8:0]  inv_neg;
   } side_type;

endpackage

// ===== src/matinv_div.sv =====
// ---------------------------------------------------------------------------
// matinv_div
// Pipelined restoring divider: one quotient bit per stage, overflow check
// in the first stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matinv_div
   import matinv_pkg::*;
#(
   parameter int NUM_W = 97
) (
   input  logic               clock,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output logic [QUO_W-1:0]   quo,
   output logic               ovf
);

   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];

   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;

   // Flag a quotient that cannot fit in the kept bits
   always_comb begin
      hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
      den_ext = CMP_W'(den);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= hi_ext[DEN_W-1:0];
      den_ff[0] <= den;
      low_ff[0] <= num[QUO_W-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= (hi_ext >= den_ext);
   end

   // One compare and subtract per stage
   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;
      logic [DEN_W:0] diff;

      always_comb begin
         trial = {rem_ff[s-1], low_ff[s-1][QUO_W-1]};
         ge    = (trial >= {1'b0, den_ff[s-1]});
         diff  = trial - {1'b0, den_ff[s-1]};
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         den_ff[s] <= den_ff[s-1];
         low_ff[s] <= {low_ff[s-1][QUO_W-2:0], 1'b0};
         quo_ff[s] <= {quo_ff[s-1][QUO_W-2:0], ge};
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule

// ===== src/matrix3x3_inverse_unit.sv =====
// ---------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Inverse and determinant of a 3x3 signed fixed-point matrix.
// ---------------------------------------------------------------------------
// A new matrix word is taken every cycle (busy stays low) and its result
// appears on rsp_valid in order; results cannot be held off. The path runs
// through the product, cofactor and determinant registers, the bit-per-stage
// dividers (one per inverse element) and one output register. Inverse
// elements are round(cof * 2^(2F) / det), ties away from zero; a zero
// determinant gives zeros with status singular, and any saturated field
// gives status saturated.
`include "assert_macros.svh"

module matrix3x3_inverse_unit
   import matinv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int NUM_A = COF_W + 2 * FRAC_BITS + 1;
   localparam int NUM_W = ((NUM_A > DMAG_W) ? NUM_A : DMAG_W) + 1;
   localparam int LAT   = 7 + DIV_LAT + 1;

   logic [LAT-1:0] vld_ff;

   // Stage 1: minor products and first row
   logic signed [31:0] m [3][3];
   logic signed [63:0] s1_pa_ff [3][3];
   logic signed [63:0] s1_pb_ff [3][3];
   logic signed [31:0] s1_m0_ff [3];
   logic signed [63:0] s1_pa_in [3][3];
   logic signed [63:0] s1_pb_in [3][3];

   always_comb begin
      int r1, r2, c1, c2;
      m[0][0] = req_data.m_r0c0; m[0][1] = req_data.m_r0c1; m[0][2] = req_data.m_r0c2;
      m[1][0] = req_data.m_r1c0; m[1][1] = req_data.m_r1c1; m[1][2] = req_data.m_r1c2;
      m[2][0] = req_data.m_r2c0; m[2][1] = req_data.m_r2c1; m[2][2] = req_data.m_r2c2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            c1 = (c == 0) ? 1 : 0;
            c2 = (c == 2) ? 1 : 2;
            s1_pa_in[r][c] = m[r1][c1] * m[r2][c2];
            s1_pb_in[r][c] = m[r1][c2] * m[r2][c1];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_pa_ff <= s1_pa_in;
      s1_pb_ff <= s1_pb_in;
      for (int c = 0; c < 3; c++) s1_m0_ff[c] <= m[0][c];
   end

   // Stage 2: cofactor magnitude and sign, first-row magnitudes
   logic [COF_W-1:0] s2_cmag_ff [3][3];
   logic             s2_cneg_ff [3][3];
   logic [31:0]      s2_m0mag_ff [3];
   logic             s2_m0neg_ff [3];
   logic [COF_W-1:0] s2_cmag_in [3][3];
   logic             s2_cneg_in [3][3];

   always_comb begin
      logic signed [64:0] dab, dba;
      logic               ge;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            dab = 65'(s1_pa_ff[r][c]) - 65'(s1_pb_ff[r][c]);
            dba = 65'(s1_pb_ff[r][c]) - 65'(s1_pa_ff[r][c]);
            ge  = (s1_pa_ff[r][c] >= s1_pb_ff[r][c]);
            s2_cmag_in[r][c] = ge ? dab[COF_W-1:0] : dba[COF_W-1:0];
            s2_cneg_in[r][c] = ((r + c) % 2 == 1) ? (s1_pb_ff[r][c] < s1_pa_ff[r][c])
                                                   : (s1_pa_ff[r][c] < s1_pb_ff[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_cmag_ff <= s2_cmag_in;
      s2_cneg_ff <= s2_cneg_in;
      for (int c = 0; c < 3; c++) begin
         s2_m0neg_ff[c] <= s1_m0_ff[c][31];
         s2_m0mag_ff[c] <= s1_m0_ff[c][31] ? 32'(32'd0 - s1_m0_ff[c]) : s1_m0_ff[c];
      end
   end

   // Stage 3: split products of the first-row expansion
   logic [COF_W-1:0] s3_cmag_ff [3][3];
   logic             s3_cneg_ff [3][3];
   logic [63:0]      s3_pl_ff [3];
   logic [63:0]      s3_ph_ff [3];
   logic             s3_tneg_ff [3];

   always_ff @(posedge clock) begin
      s3_cmag_ff <= s2_cmag_ff;
      s3_cneg_ff <= s2_cneg_ff;
      for (int c = 0; c < 3; c++) begin
         s3_pl_ff[c]   <= 64'(s2_m0mag_ff[c]) * 64'(s2_cmag_ff[0][c][31:0]);
         s3_ph_ff[c]   <= 64'(s2_m0mag_ff[c]) * 64'(s2_cmag_ff[0][c][63:32]);
         s3_tneg_ff[c] <= s2_m0neg_ff[c] != s2_cneg_ff[0][c];
      end
   end

   // Stage 4: signed terms
   logic [COF_W-1:0] s4_cmag_ff [3][3];
   logic             s4_cneg_ff [3][3];
   logic [DET_W-1:0] s4_term_ff [3];

   always_ff @(posedge clock) begin
      logic [DMAG_W-1:0] sum;
      s4_cmag_ff <= s3_cmag_ff;
      s4_cneg_ff <= s3_cneg_ff;
      for (int c = 0; c < 3; c++) begin
         sum = {s3_ph_ff[c], 32'h0} + DMAG_W'(s3_pl_ff[c]);
         s4_term_ff[c] <= s3_tneg_ff[c] ? (DET_W'(0) - {1'b0, sum}) : {1'b0, sum};
      end
   end

   // Stage 5: determinant
   logic [COF_W-1:0] s5_cmag_ff [3][3];
   logic             s5_cneg_ff [3][3];
   logic [DET_W-1:0] s5_det_ff;

   always_ff @(posedge clock) begin
      s5_cmag_ff <= s4_cmag_ff;
      s5_cneg_ff <= s4_cneg_ff;
      s5_det_ff  <= s4_term_ff[0] + s4_term_ff[1] + s4_term_ff[2];
   end

   // Stage 6: determinant magnitude, sign and singular flag
   logic [COF_W-1:0]  s6_cmag_ff [3][3];
   logic              s6_cneg_ff [3][3];
   logic [DMAG_W-1:0] s6_dmag_ff;
   logic              s6_dneg_ff;
   logic              s6_sing_ff;
   logic [DET_W-1:0]  s6_dn;

   assign s6_dn = DET_W'(0) - s5_det_ff;

   always_ff @(posedge clock) begin
      s6_cmag_ff <= s5_cmag_ff;
      s6_cneg_ff <= s5_cneg_ff;
      s6_dneg_ff <= s5_det_ff[DET_W-1];
      s6_dmag_ff <= s5_det_ff[DET_W-1] ? s6_dn[DMAG_W-1:0] : s5_det_ff[DMAG_W-1:0];
      s6_sing_ff <= (s5_det_ff == '0);
   end

   // Stage 7: numerators, divisor and rounded determinant
   logic [NUM_W-1:0] s7_num_ff [9];
   logic [DEN_W-1:0] s7_den_ff;
   side_type         s7_side_ff;
   side_type         s7_side_in;

   always_comb begin
      logic [DET_W-1:0] dr;
      logic [DET_W-1:0] lim;
      logic [31:0]      dmag32;
      dr  = (DET_W'(s6_dmag_ff) + (DET_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      lim = s6_dneg_ff ? DET_W'(33'h080000000) : DET_W'(33'h07FFFFFFF);
      s7_side_in.sing    = s6_sing_ff;
      s7_side_in.det_sat = (dr > lim);
      dmag32 = s7_side_in.det_sat ? lim[31:0] : dr[31:0];
      s7_side_in.det_val = s6_dneg_ff ? (32'd0 - dmag32) : dmag32;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s7_side_in.inv_neg[r * 3 + c] = s6_cneg_ff[c][r] != s6_dneg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s7_den_ff  <= {s6_dmag_ff, 1'b0};
      s7_side_ff <= s7_side_in;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s7_num_ff[r * 3 + c] <= (NUM_W'(s6_cmag_ff[c][r]) << (2 * FRAC_BITS + 1))
                                    + NUM_W'(s6_dmag_ff);
         end
      end
   end

   // Dividers, one per inverse element
   logic [QUO_W-1:0] quo [9];
   logic             ovf [9];

   for (genvar k = 0; k < 9; k++) begin : g_div
      matinv_div #(
         .NUM_W (NUM_W)
      ) u_div (
         .clock (clock),
         .num   (s7_num_ff[k]),
         .den   (s7_den_ff),
         .quo   (quo[k]),
         .ovf   (ovf[k])
      );
   end

   // Hold per-word flags beside the dividers
   side_type side_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      side_ff[0] <= s7_side_ff;
      for (int s = 1; s < DIV_LAT; s++) side_ff[s] <= side_ff[s-1];
   end

   // Output: sign, saturate and pack
   rsp_type rsp_in;
   rsp_type rsp_ff;

   always_comb begin
      logic [31:0] inv [9];
      logic [31:0] lim;
      logic [31:0] mag;
      logic        sat;
      logic        any_sat;
      side_type    sd;
      sd      = side_ff[DIV_LAT-1];
      any_sat = sd.det_sat;
      for (int k = 0; k < 9; k++) begin
         lim     = sd.inv_neg[k] ? 32'h80000000 : 32'h7FFFFFFF;
         sat     = ovf[k] || (quo[k] > lim);
         mag     = sat ? lim : quo[k];
         inv[k]  = sd.inv_neg[k] ? (32'd0 - mag) : mag;
         any_sat = any_sat | sat;
      end
      rsp_in.inv_r0c0  = inv[0];
      rsp_in.inv_r0c1  = inv[1];
      rsp_in.inv_r0c2  = inv[2];
      rsp_in.inv_r1c0  = inv[3];
      rsp_in.inv_r1c1  = inv[4];
      rsp_in.inv_r1c2  = inv[5];
      rsp_in.inv_r2c0  = inv[6];
      rsp_in.inv_r2c1  = inv[7];
      rsp_in.inv_r2c2  = inv[8];
      rsp_in.det_value = sd.det_val;
      rsp_in.status    = any_sat ? STATUS_SAT : STATUS_OK;
      if (sd.sing) begin
         rsp_in        = '0;
         rsp_in.status = STATUS_SINGULAR;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Advance valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPL(a_latency, rsp_valid, $past(start && !busy, LAT), "result without a word")
   `ASSERT_IMPL(a_sing_zero, rsp_valid && rsp_data.status == STATUS_SINGULAR, rsp_data.det_value == '0 && rsp_data.inv_r1c1 == '0, "singular result not zeroed")
   `ASSERT_IMPL(a_sing_track, rsp_valid && $past(vld_ff[5] && s6_sing_ff, LAT - 6), rsp_data.status == STATUS_SINGULAR, "singular flag lost")
   `ASSERT_NEXT(a_det_sat, vld_ff[LAT-2] && !side_ff[DIV_LAT-1].sing && side_ff[DIV_LAT-1].det_sat, rsp_data.status == STATUS_SAT, "determinant saturation not reported")

endmodule

// ===== dv/matrix3x3_inverse_checker.sv =====
// ---------------------------------------------------------------------------
// matrix3x3_inverse_checker
// Watches the matrix and result channels, predicts the inverse and the
// determinant of every accepted matrix word and compares the results in order.
// ---------------------------------------------------------------------------
module matrix3x3_inverse_checker
   import matinv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRAC_BITS_DEF;

   rsp_type inverse_queue[$];
   int      mismatch_count;

   // Saturate a magnitude with sign to 32 bits
   function automatic logic [31:0] pack_sat(logic [127:0] mag, logic neg, ref logic sat);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag > lim) begin
         sat = 1'b1;
         mag = lim;
      end
      return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
   endfunction

   function automatic logic signed [127:0] elem(req_type m, int r, int c);
      logic signed [31:0] v[9];
      v = '{m.m_r0c0, m.m_r0c1, m.m_r0c2, m.m_r1c0, m.m_r1c1, m.m_r1c2,
            m.m_r2c0, m.m_r2c1, m.m_r2c2};
      return 128'(v[r * 3 + c]);
   endfunction

   // Adjugate over the exact determinant, rounded once
   function automatic rsp_type invert(req_type m);
      logic signed [127:0] cof[3][3];
      logic signed [127:0] det, cv;
      logic [127:0]        dmag, cmag, q;
      logic [31:0]         res[10];
      logic                dneg, sat;
      int                  r1, r2, c1, c2;
      rsp_type             o;
      det = 0;
      sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            c1 = (c == 0) ? 1 : 0;
            c2 = (c == 2) ? 1 : 2;
            cv = elem(m, r1, c1) * elem(m, r2, c2) - elem(m, r1, c2) * elem(m, r2, c1);
            cof[r][c] = ((r + c) % 2 == 1) ? -cv : cv;
         end
      end
      for (int c = 0; c < 3; c++) det = det + elem(m, 0, c) * cof[0][c];
      o = '0;
      if (det == 0) begin
         o.status = STATUS_SINGULAR;
         return o;
      end
      dneg = det[127];
      dmag = dneg ? -det : det;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cv   = cof[c][r];
            cmag = cv[127] ? -cv : cv;
            q    = ((cmag << (2 * FB + 1)) + dmag) / (dmag << 1);
            res[r * 3 + c] = pack_sat(q, cv[127] != dneg, sat);
         end
      end
      q = (dmag + (128'd1 << (2 * FB - 1))) >> (2 * FB);
      res[9] = pack_sat(q, dneg, sat);
      o.inv_r0c0 = res[0]; o.inv_r0c1 = res[1]; o.inv_r0c2 = res[2];
      o.inv_r1c0 = res[3]; o.inv_r1c1 = res[4]; o.inv_r1c2 = res[5];
      o.inv_r2c0 = res[6]; o.inv_r2c1 = res[7]; o.inv_r2c2 = res[8];
      o.det_value = res[9];
      o.status = sat ? STATUS_SAT : STATUS_OK;
      return o;
   endfunction

   // Predict on accept, compare on strobe
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count     <= 0;
         pending        <= 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (inverse_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (mismatch_count < 10) $display("unexpected result word %h", rsp_data);
               mismatch_count++;
            end else begin
               want = inverse_queue.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: expected %h actual %h", want, rsp_data);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) inverse_queue.push_back(invert(req_data));
         pending <= inverse_queue.size();
      end
   end
endmodule

// ===== dv/tb_matrix3x3_inverse_unit.sv =====
// ---------------------------------------------------------------------------
// tb_matrix3x3_inverse_unit
// Drives directed and random matrix words in bursts into the inverse unit
// and reports the verdict from the checker's failure and pending counts.
// ---------------------------------------------------------------------------
module tb_matrix3x3_inverse_unit
   import matinv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ONE = 32'h0001_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;

   matrix3x3_inverse_unit dut (.*);
   matrix3x3_inverse_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("matrix3x3_inverse_unit test failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_elem(int mode);
      unique case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
         2: return 32'($signed($urandom_range(0, 512)) - 256);
         3: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      endcase
   endfunction

   function automatic req_type rand_matrix();
      req_type m;
      int      mode;
      mode = $urandom_range(0, 4);
      m = {rand_elem(mode), rand_elem(mode), rand_elem(mode), rand_elem(mode),
           rand_elem(mode), rand_elem(mode), rand_elem(mode), rand_elem(mode),
           rand_elem(mode)};
      // Sometimes copy a row so the matrix is singular
      if ($urandom_range(0, 9) == 0) begin
         m.m_r2c0 = m.m_r0c0;
         m.m_r2c1 = m.m_r0c1;
         m.m_r2c2 = m.m_r0c2;
      end
      return m;
   endfunction

   // Hold one word until taken; after the last of a burst, drop start for a gap
   task automatic send(req_type m, logic last_in_burst);
      req_data <= m;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (last_in_burst) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   req_type directed[$];
   int      burst;

   initial begin
      directed.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
      directed.push_back('{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE});
      directed.push_back('{-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
      directed.push_back('0);
      directed.push_back('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, ONE});
      directed.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
      directed.push_back('{256, 0, 0, 0, 256, 0, 0, 0, 256});
      directed.push_back('{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF});
      directed.push_back('{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000});
      directed.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000,
                           -1, 3, 5, 32'h8000_0000});
      directed.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
      directed.push_back('{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE});
      directed.push_back('{ONE / 2, 0, 0, 0, ONE / 4, 0, 0, 0, 3 * ONE});
      directed.push_back('{0, ONE, 0, ONE, 0, 0, 0, 0, -ONE});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send(directed[i], $urandom_range(0, 2) == 0);
      burst = 0;
      for (int n = 0; n < 1150; n++) begin
         if (burst == 0) burst = $urandom_range(1, 40);
         burst--;
         send(rand_matrix(), burst == 0);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("matrix3x3_inverse_unit test passed");
      end else begin
         $display("matrix3x3_inverse_unit test failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/matinv_pkg.sv
src/matinv_div.sv
src/matrix3x3_inverse_unit.sv
dv/matrix3x3_inverse_checker.sv
dv/tb_matrix3x3_inverse_unit.sv
